>>> rtl/core/partition_load_hotspot_monitor_core_defines.svh
// Assertion macros for the partition load hotspot monitor.
// No dependencies.
`ifndef PARTITION_LOAD_HOTSPOT_MONITOR_CORE_DEFINES_SVH
`define PARTITION_LOAD_HOTSPOT_MONITOR_CORE_DEFINES_SVH
// Implication checked at every rising clock edge, off during reset.
`define PLHM_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication checked at every rising clock edge, off during reset.
`define PLHM_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> rtl/core/plhm_pkg.sv
// Shared types and constants for the partition load hotspot monitor.
// No dependencies.
package plhm_pkg;
  localparam int RATE_W = 42;
  localparam int THR_W  = 44;
  localparam int CPU_W  = 24;
  localparam int ITV_W  = 16;
  localparam int WIN_W  = 8;
  localparam int CFG_W  = 44;
  localparam int OP_W   = 3;

  localparam logic [OP_W-1:0] OP_ACCESS = 3'd0;
  localparam logic [OP_W-1:0] OP_CPU    = 3'd1;
  localparam logic [OP_W-1:0] OP_DETECT = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_RATE_THR = 2'd1;
  localparam logic [1:0] REG_CPU_THR  = 2'd2;
  localparam logic [1:0] REG_WINDOW   = 2'd3;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam int unsigned RATE_SCALE = 1000;
  localparam int unsigned WIN_DEFAULT = 10;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic do_access;  // apply access update
    logic cpu_start;  // start cpu average division
    logic cpu_commit; // write divided average back
    logic do_clear;   // clear all counters
    logic div_start;  // start a rate division
    logic scan_div;   // rate division reads the scan entry
    logic [1:0] div_sel; // 0 read, 1 write, 2 sum
    logic div_store;  // keep division result
    logic scan_clear; // reset best and candidate count
    logic scan_eval;  // evaluate one candidate
    logic scan_mark;  // mark best as emitted
    logic emit_det;   // emit best as detect result
    logic emit_none;  // emit empty detect answer
    logic emit_query; // emit query answer
    logic set_last;   // last flag for this emission
  } plhm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic best_valid;
    logic one_left;   // only one candidate found in the last pass
  } plhm_sts_t;
endpackage

>>> rtl/core/partition_load_hotspot_monitor_core.sv
// Partition load hotspot monitor, top level: controller plus datapath.
// Depends on plhm_pkg, plhm_ctrl, plhm_datapath.
//
// One transaction is taken when start is high and busy is low; the block
// handles one transaction at a time. Access and reset-counter ops need no
// division. A cpu sample runs through the serial cpu average divider (one
// bit per cycle over 32 bits). A query runs three serial rate divisions and
// then strobes its result. A detect runs one pass per reported partition
// (one pass when nothing is hot); each pass runs two rate divisions per
// entry and reports one hot partition. Results appear on out_valid for one
// cycle each and cannot be stalled.
module partition_load_hotspot_monitor_core #(
  parameter int PARTITIONS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [plhm_pkg::OP_W-1:0]   in_op,
  input  logic [3:0]                  in_partition,
  input  logic                        in_is_write,
  input  logic [15:0]                 in_access_count,
  input  logic [plhm_pkg::CPU_W-1:0]  in_cpu_sample,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [plhm_pkg::CFG_W-1:0]  cfg_data,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [3:0]                  out_part_index,
  output logic [plhm_pkg::RATE_W-1:0] out_read_rate,
  output logic [plhm_pkg::RATE_W-1:0] out_write_rate,
  output logic [plhm_pkg::CPU_W-1:0]  out_cpu_average,
  output logic                        out_hot,
  output logic                        out_last
);
  plhm_pkg::plhm_cmd_t cmd;
  plhm_pkg::plhm_sts_t sts;
  logic [$clog2(PARTITIONS)-1:0] scan_idx;

  plhm_ctrl #(.PARTITIONS(PARTITIONS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_op(in_op), .busy(busy),
    .cmd(cmd), .sts(sts), .scan_idx(scan_idx)
  );

  plhm_datapath #(.PARTITIONS(PARTITIONS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .scan_idx(scan_idx),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_partition(in_partition), .in_is_write(in_is_write),
    .in_access_count(in_access_count), .in_cpu_sample(in_cpu_sample),
    .out_valid(out_valid), .out_found(out_found), .out_part_index(out_part_index),
    .out_read_rate(out_read_rate), .out_write_rate(out_write_rate),
    .out_cpu_average(out_cpu_average), .out_hot(out_hot), .out_last(out_last)
  );
endmodule

>>> rtl/core/plhm_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module plhm_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next numerator bit, subtract when it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) den_r <= den;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = quo_r;
endmodule

>>> rtl/core/plhm_datapath.sv
// Datapath: partition table, configuration, rate divisions and the detect scan.
// Depends on plhm_pkg and plhm_divider.
`include "partition_load_hotspot_monitor_core_defines.svh"
module plhm_datapath #(
  parameter int PARTITIONS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  plhm_pkg::plhm_cmd_t           cmd,
  output plhm_pkg::plhm_sts_t           sts,
  input  logic [$clog2(PARTITIONS)-1:0] scan_idx,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [plhm_pkg::CFG_W-1:0]    cfg_data,
  input  logic [3:0]                    in_partition,
  input  logic                          in_is_write,
  input  logic [15:0]                   in_access_count,
  input  logic [plhm_pkg::CPU_W-1:0]    in_cpu_sample,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [3:0]                    out_part_index,
  output logic [plhm_pkg::RATE_W-1:0]   out_read_rate,
  output logic [plhm_pkg::RATE_W-1:0]   out_write_rate,
  output logic [plhm_pkg::CPU_W-1:0]    out_cpu_average,
  output logic                          out_hot,
  output logic                          out_last
);
  localparam int IDX_W = $clog2(PARTITIONS);
  localparam int SUM_W = COUNT_BITS + 1;
  localparam int NUM_W = SUM_W + 10;
  localparam int CPU_W = plhm_pkg::CPU_W;
  localparam int RATE_W = plhm_pkg::RATE_W;
  localparam int ITV_W = plhm_pkg::ITV_W;
  localparam int THR_W = plhm_pkg::THR_W;
  localparam int WIN_W = plhm_pkg::WIN_W;
  localparam int CNUM_W = CPU_W + WIN_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [ITV_W-1:0] interval_r;
  logic [THR_W-1:0] rate_thr_r;
  logic [CPU_W-1:0] cpu_thr_r;
  logic [WIN_W-1:0] window_r;

  logic [PARTITIONS-1:0]  present_r, emitted_r;
  logic [COUNT_BITS-1:0]  rd_cnt_r [PARTITIONS];
  logic [COUNT_BITS-1:0]  wr_cnt_r [PARTITIONS];
  logic [CPU_W-1:0]       cpu_avg_r [PARTITIONS];

  logic [3:0]            part_r;
  logic                  is_write_r;
  logic [15:0]           amt_r;
  logic [CPU_W-1:0]      sample_r;
  logic [IDX_W-1:0]      pidx;
  logic                  in_range;

  // Scratch for the entry under work
  logic [RATE_W-1:0] rr_r, wr_r, tot_r;
  logic [IDX_W-1:0]  best_r;
  logic              best_v_r;
  logic [RATE_W:0]   best_tot_r;
  logic [RATE_W-1:0] best_rr_r, best_wr_r;
  logic [IDX_W:0]    elig_cnt_r;

  always_comb begin
    pidx = IDX_W'(part_r);
    in_range = (5'(part_r) < 5'(PARTITIONS)) || (PARTITIONS >= 16);
  end

  // Rate divider input
  logic [IDX_W-1:0]  cur_idx;
  logic [SUM_W-1:0]  cnt_sel;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic              div_done;
  logic [RATE_W-1:0] div_rate;

  assign cur_idx = cmd.scan_div ? scan_idx : pidx;
  always_comb begin
    case (cmd.div_sel)
      2'd0: cnt_sel = SUM_W'(rd_cnt_r[cur_idx]);
      2'd1: cnt_sel = SUM_W'(wr_cnt_r[cur_idx]);
      default: cnt_sel = SUM_W'(rd_cnt_r[cur_idx]) + SUM_W'(wr_cnt_r[cur_idx]);
    endcase
    // count*1000 = count*1024 - count*16 - count*8
    div_num = (NUM_W'(cnt_sel) << 10) - (NUM_W'(cnt_sel) << 4) - (NUM_W'(cnt_sel) << 3);
  end

  plhm_divider #(.NUM_W(NUM_W), .DEN_W(ITV_W)) u_rdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num),
    .den(interval_r), .done(div_done), .quo(div_quo)
  );

  always_comb begin
    if (interval_r == '0) div_rate = plhm_pkg::RATE_MAX;
    else if ((div_quo >> RATE_W) != '0) div_rate = plhm_pkg::RATE_MAX;
    else div_rate = div_quo[RATE_W-1:0];
  end

  // Cpu average divider
  logic [WIN_W-1:0]  w_eff;
  logic [CNUM_W-1:0] cnum_r, cquo;
  logic              cdone;
  assign w_eff = (window_r == '0) ? WIN_W'(plhm_pkg::WIN_DEFAULT) : window_r;

  // old*(w-1)+sample, registered before division
  always_ff @(posedge clk) begin
    if (cmd.cpu_start)
      cnum_r <= CNUM_W'(cpu_avg_r[pidx]) * CNUM_W'(w_eff - 1'b1) + CNUM_W'(sample_r);
  end

  logic cstart_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cstart_r <= 1'b0;
    else cstart_r <= cmd.cpu_start;
  end

  plhm_divider #(.NUM_W(CNUM_W), .DEN_W(WIN_W)) u_cdiv (
    .clk(clk), .rst_n(rst_n), .start(cstart_r), .num(cnum_r),
    .den(w_eff), .done(cdone), .quo(cquo)
  );

  assign sts.div_done = div_done | cdone;
  assign sts.best_valid = best_v_r;
  assign sts.one_left = (elig_cnt_r == (IDX_W+1)'(1));

  logic [RATE_W:0] cand_tot;
  logic            cand_hot;
  logic            cand_elig;
  assign cand_tot = {1'b0, rr_r} + {1'b0, wr_r};
  assign cand_hot = ({1'b0, cand_tot} > rate_thr_r) || (cpu_avg_r[scan_idx] > cpu_thr_r);
  assign cand_elig = present_r[scan_idx] && !emitted_r[scan_idx] && cand_hot;

  logic [COUNT_BITS:0] acc_sum;
  always_comb begin
    acc_sum = is_write_r ? {1'b0, wr_cnt_r[pidx]} : {1'b0, rd_cnt_r[pidx]};
    acc_sum = acc_sum + (COUNT_BITS+1)'(amt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= ITV_W'(1000);
      rate_thr_r <= THR_W'(10000);
      cpu_thr_r <= CPU_W'(52429);
      window_r <= WIN_W'(10);
      present_r <= '0;
      emitted_r <= '0;
      best_v_r <= 1'b0;
      best_tot_r <= '0;
      elig_cnt_r <= '0;
      for (int i = 0; i < PARTITIONS; i++) begin
        rd_cnt_r[i] <= '0;
        wr_cnt_r[i] <= '0;
        cpu_avg_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          plhm_pkg::REG_INTERVAL: interval_r <= cfg_data[ITV_W-1:0];
          plhm_pkg::REG_RATE_THR: rate_thr_r <= cfg_data[THR_W-1:0];
          plhm_pkg::REG_CPU_THR:  cpu_thr_r  <= cfg_data[CPU_W-1:0];
          plhm_pkg::REG_WINDOW:   window_r   <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.latch) begin
        part_r <= in_partition;
        is_write_r <= in_is_write;
        amt_r <= in_access_count;
        sample_r <= in_cpu_sample;
        emitted_r <= '0;
      end
      if (cmd.div_store) begin
        case (cmd.div_sel)
          2'd0: rr_r <= div_rate;
          2'd1: wr_r <= div_rate;
          default: tot_r <= div_rate;
        endcase
      end
      if (cmd.do_access && in_range) begin
        present_r[pidx] <= 1'b1;
        if (is_write_r)
          wr_cnt_r[pidx] <= acc_sum[COUNT_BITS] ? CNT_MAX : acc_sum[COUNT_BITS-1:0];
        else
          rd_cnt_r[pidx] <= acc_sum[COUNT_BITS] ? CNT_MAX : acc_sum[COUNT_BITS-1:0];
      end
      if (cmd.cpu_start && in_range) present_r[pidx] <= 1'b1;
      if (cmd.cpu_commit && in_range) cpu_avg_r[pidx] <= cquo[CPU_W-1:0];
      if (cmd.do_clear) begin
        for (int i = 0; i < PARTITIONS; i++) begin
          rd_cnt_r[i] <= '0;
          wr_cnt_r[i] <= '0;
        end
      end
      if (cmd.scan_clear) begin
        best_v_r <= 1'b0;
        best_tot_r <= '0;
        elig_cnt_r <= '0;
      end
      if (cmd.scan_eval && cand_elig) begin
        elig_cnt_r <= elig_cnt_r + 1'b1;
        // strict greater keeps the lower index on ties
        if (!best_v_r || cand_tot > best_tot_r) begin
          best_v_r <= 1'b1;
          best_r <= scan_idx;
          best_tot_r <= cand_tot;
          best_rr_r <= rr_r;
          best_wr_r <= wr_r;
        end
      end
      if (cmd.scan_mark) emitted_r[best_r] <= 1'b1;
      if (cmd.emit_det) begin
        out_found <= 1'b1;
        out_part_index <= 4'(best_r);
        out_read_rate <= best_rr_r;
        out_write_rate <= best_wr_r;
        out_cpu_average <= cpu_avg_r[best_r];
        out_hot <= 1'b1;
        out_last <= cmd.set_last;
      end else if (cmd.emit_none) begin
        out_found <= 1'b0;
        out_part_index <= '0;
        out_read_rate <= '0;
        out_write_rate <= '0;
        out_cpu_average <= '0;
        out_hot <= 1'b0;
        out_last <= 1'b1;
      end else if (cmd.emit_query) begin
        out_part_index <= part_r;
        out_last <= 1'b1;
        if (in_range) begin
          out_found <= present_r[pidx];
          out_read_rate <= rr_r;
          out_write_rate <= wr_r;
          out_cpu_average <= cpu_avg_r[pidx];
          out_hot <= present_r[pidx] && (({2'b0, tot_r} > rate_thr_r) ||
                     cpu_avg_r[pidx] > cpu_thr_r);
        end else begin
          out_found <= 1'b0;
          out_read_rate <= '0;
          out_write_rate <= '0;
          out_cpu_average <= '0;
          out_hot <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit_det | cmd.emit_none | cmd.emit_query;
  end

  `PLHM_ASSERT_IMP(a_one_emit, clk, rst_n,
    cmd.emit_det || cmd.emit_none || cmd.emit_query,
    $onehot({cmd.emit_det, cmd.emit_none, cmd.emit_query}))
  `PLHM_ASSERT_IMP(a_det_best, clk, rst_n, cmd.emit_det, best_v_r)
  `PLHM_ASSERT_NXT(a_mark_sets, clk, rst_n, cmd.scan_mark, emitted_r[$past(best_r)])
endmodule

>>> rtl/core/plhm_ctrl.sv
// Controller state machine sequencing ops over the datapath.
// Depends on plhm_pkg.
`include "partition_load_hotspot_monitor_core_defines.svh"
module plhm_ctrl #(
  parameter int PARTITIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plhm_pkg::OP_W-1:0]     in_op,
  output logic                          busy,
  output plhm_pkg::plhm_cmd_t           cmd,
  input  plhm_pkg::plhm_sts_t           sts,
  output logic [$clog2(PARTITIONS)-1:0] scan_idx
);
  localparam int IDX_W = $clog2(PARTITIONS);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_CPUW   = 4'd2;
  localparam logic [3:0] S_QDIV   = 4'd3;
  localparam logic [3:0] S_QWAIT  = 4'd4;
  localparam logic [3:0] S_QEMIT  = 4'd5;
  localparam logic [3:0] S_DDIV   = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_DEVAL  = 4'd8;
  localparam logic [3:0] S_DEMIT  = 4'd9;
  localparam logic [3:0] S_CPUS   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [plhm_pkg::OP_W-1:0] op_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic any_r, any_nxt;

  assign busy = (state_r != S_IDLE);
  assign scan_idx = idx_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    idx_nxt = idx_r;
    sel_nxt = sel_r;
    any_nxt = any_r;
    cmd.div_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          plhm_pkg::OP_ACCESS: begin
            cmd.do_access = 1'b1;
            state_nxt = S_IDLE;
          end
          plhm_pkg::OP_CPU: begin
            cmd.cpu_start = 1'b1;
            state_nxt = S_CPUS;
          end
          plhm_pkg::OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_nxt = S_IDLE;
          end
          plhm_pkg::OP_QUERY: begin
            sel_nxt = 2'd0;
            state_nxt = S_QDIV;
          end
          plhm_pkg::OP_DETECT: begin
            idx_nxt = '0;
            sel_nxt = 2'd0;
            any_nxt = 1'b0;
            cmd.scan_clear = 1'b1;
            state_nxt = S_DDIV;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CPUS: state_nxt = S_CPUW;
      S_CPUW: begin
        if (sts.div_done) begin
          cmd.cpu_commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QDIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (sel_r == 2'd2) state_nxt = S_QEMIT;
          else begin
            sel_nxt = sel_r + 2'd1;
            state_nxt = S_QDIV;
          end
        end
      end
      S_QEMIT: begin
        cmd.emit_query = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DDIV: begin
        cmd.div_start = 1'b1;
        cmd.scan_div = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (sel_r == 2'd1) state_nxt = S_DEVAL;
          else begin
            sel_nxt = 2'd1;
            state_nxt = S_DDIV;
          end
        end
      end
      S_DEVAL: begin
        cmd.scan_eval = 1'b1;
        sel_nxt = 2'd0;
        if (idx_r == IDX_W'(PARTITIONS - 1)) begin
          idx_nxt = '0;
          state_nxt = S_DEMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_DDIV;
        end
      end
      S_DEMIT: begin
        // emit the pass winner; it is last when it was the only candidate left
        if (sts.best_valid) begin
          cmd.scan_mark = 1'b1;
          cmd.emit_det = 1'b1;
          cmd.set_last = sts.one_left;
          any_nxt = 1'b1;
          if (sts.one_left) state_nxt = S_IDLE;
          else begin
            cmd.scan_clear = 1'b1;
            state_nxt = S_DDIV;
          end
        end else begin
          if (!any_r) cmd.emit_none = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) op_r <= in_op;
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      sel_r <= '0;
      any_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      sel_r <= sel_nxt;
      any_r <= any_nxt;
    end
  end

  `PLHM_ASSERT_IMP(a_idle_no_cmd, clk, rst_n, state_r == S_IDLE,
    !cmd.emit_det && !cmd.emit_query && !cmd.div_start)
  `PLHM_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PLHM_ASSERT_NXT(a_last_idle, clk, rst_n, cmd.emit_det && cmd.set_last,
    state_r == S_IDLE)
endmodule

>>> verif/tb_partition_load_hotspot_monitor_core.sv
// Self-checking testbench for partition_load_hotspot_monitor_core.
// Depends on plhm_pkg and the core RTL; a scoreboard class predicts every
// answer from its own copy of the partition table and checks each strobe.
`timescale 1ns / 100ps

module tb_partition_load_hotspot_monitor_core;
  localparam int NPART = 16;
  localparam int RATE_W = plhm_pkg::RATE_W;
  localparam int CPU_W = plhm_pkg::CPU_W;
  localparam int THR_W = plhm_pkg::THR_W;
  localparam int CFG_W = plhm_pkg::CFG_W;
  localparam int OP_W = plhm_pkg::OP_W;
  localparam longint unsigned COUNT_CAP = 64'hFFFF_FFFF;
  localparam longint unsigned CYCLE_LIMIT = 50000000;

  typedef struct {
    bit              found;
    bit [3:0]        idx;
    bit [RATE_W-1:0] rd_rate;
    bit [RATE_W-1:0] wr_rate;
    bit [CPU_W-1:0]  cpu_avg;
    bit              hot;
    bit              last;
  } part_report_t;

  class load_scoreboard;
    longint unsigned itv, rate_thr, cpu_thr, win;
    bit              present [NPART];
    longint unsigned rd_cnt [NPART];
    longint unsigned wr_cnt [NPART];
    longint unsigned cpu_avg [NPART];
    part_report_t    reports_due [$];
    int              errors;

    function new();
      itv = 1000; rate_thr = 10000; cpu_thr = 52429; win = 10;
      errors = 0;
      for (int i = 0; i < NPART; i++) begin
        present[i] = 0; rd_cnt[i] = 0; wr_cnt[i] = 0; cpu_avg[i] = 0;
      end
    endfunction

    function void set_reg(bit [1:0] idx, longint unsigned val);
      case (idx)
        plhm_pkg::REG_INTERVAL: itv = val & 64'hFFFF;
        plhm_pkg::REG_RATE_THR: rate_thr = val & ((64'd1 << THR_W) - 1);
        plhm_pkg::REG_CPU_THR:  cpu_thr = val & 64'hFF_FFFF;
        plhm_pkg::REG_WINDOW:   win = val & 64'hFF;
        default: ;
      endcase
    endfunction

    function longint unsigned per_sec(longint unsigned cnt);
      longint unsigned r;
      if (itv == 0) return plhm_pkg::RATE_MAX;
      r = cnt * 1000 / itv;
      return (r > plhm_pkg::RATE_MAX) ? plhm_pkg::RATE_MAX : r;
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    // Append one expected answer at the tail.
    function void expect_report(part_report_t r);
      reports_due.insert(reports_due.size(), r);
    endfunction

    // Note an accepted transaction and queue the answers it causes.
    function void note(bit [2:0] op, bit [3:0] p, bit is_wr, bit [15:0] cnt,
                       bit [23:0] smp);
      part_report_t    r;
      bit              done [NPART];
      int              best, n;
      longint unsigned w, t, best_t, sum;
      case (op)
        plhm_pkg::OP_ACCESS: begin
          present[p] = 1;
          if (is_wr) begin
            wr_cnt[p] = wr_cnt[p] + cnt;
            if (wr_cnt[p] > COUNT_CAP) wr_cnt[p] = COUNT_CAP;
          end else begin
            rd_cnt[p] = rd_cnt[p] + cnt;
            if (rd_cnt[p] > COUNT_CAP) rd_cnt[p] = COUNT_CAP;
          end
        end
        plhm_pkg::OP_CPU: begin
          w = (win == 0) ? 10 : win;
          present[p] = 1;
          cpu_avg[p] = ((cpu_avg[p] * (w - 1) + smp) / w) & 64'hFF_FFFF;
        end
        plhm_pkg::OP_DETECT: begin
          n = 0;
          for (int i = 0; i < NPART; i++) done[i] = 0;
          forever begin
            best = -1; best_t = 0;
            for (int i = 0; i < NPART; i++) begin
              if (!present[i] || done[i]) continue;
              t = per_sec(rd_cnt[i]) + per_sec(wr_cnt[i]);
              if (!(t > rate_thr || cpu_avg[i] > cpu_thr)) continue;
              if (best < 0 || t > best_t) begin
                best = i; best_t = t;
              end
            end
            if (best < 0) break;
            done[best] = 1;
            r.found = 1; r.idx = 4'(best); r.rd_rate = RATE_W'(per_sec(rd_cnt[best]));
            r.wr_rate = RATE_W'(per_sec(wr_cnt[best])); r.cpu_avg = CPU_W'(cpu_avg[best]);
            r.hot = 1; r.last = 0;
            expect_report(r);
            n++;
          end
          if (n == 0) begin
            r = '{0, 0, 0, 0, 0, 0, 1};
            expect_report(r);
          end else begin
            reports_due[reports_due.size() - 1].last = 1;
          end
        end
        plhm_pkg::OP_CLEAR: begin
          for (int i = 0; i < NPART; i++) begin
            rd_cnt[i] = 0; wr_cnt[i] = 0;
          end
        end
        plhm_pkg::OP_QUERY: begin
          sum = rd_cnt[p] + wr_cnt[p];
          if (itv == 0) t = plhm_pkg::RATE_MAX;
          else begin
            t = sum * 1000 / itv;
            if (t > plhm_pkg::RATE_MAX) t = plhm_pkg::RATE_MAX;
          end
          r.found = present[p]; r.idx = p; r.rd_rate = RATE_W'(per_sec(rd_cnt[p]));
          r.wr_rate = RATE_W'(per_sec(wr_cnt[p])); r.cpu_avg = CPU_W'(cpu_avg[p]);
          r.hot = present[p] && (t > rate_thr || cpu_avg[p] > cpu_thr);
          r.last = 1;
          expect_report(r);
        end
        default: ;
      endcase
    endfunction

    function void check(part_report_t got);
      part_report_t exp;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result for partition %0d", $time, got.idx);
        errors++;
        return;
      end
      exp = reports_due.pop_front();
      if (got.found !== exp.found) begin
        $display("%0t: found exp %0d got %0d", $time, exp.found, got.found);
        errors++;
      end
      if (got.idx !== exp.idx) begin
        $display("%0t: part_index exp %0d got %0d", $time, exp.idx, got.idx);
        errors++;
      end
      if (got.rd_rate !== exp.rd_rate) begin
        $display("%0t: read_rate exp %0d got %0d", $time, exp.rd_rate, got.rd_rate);
        errors++;
      end
      if (got.wr_rate !== exp.wr_rate) begin
        $display("%0t: write_rate exp %0d got %0d", $time, exp.wr_rate, got.wr_rate);
        errors++;
      end
      if (got.cpu_avg !== exp.cpu_avg) begin
        $display("%0t: cpu_average exp %0h got %0h", $time, exp.cpu_avg, got.cpu_avg);
        errors++;
      end
      if (got.hot !== exp.hot) begin
        $display("%0t: hot exp %0d got %0d", $time, exp.hot, got.hot);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [OP_W-1:0]   in_op = plhm_pkg::OP_ACCESS;
  logic [3:0]        in_partition = 0;
  logic              in_is_write = 0;
  logic [15:0]       in_access_count = 0;
  logic [CPU_W-1:0]  in_cpu_sample = 0;
  logic              cfg_we = 0;
  logic [1:0]        cfg_index = plhm_pkg::REG_INTERVAL;
  logic [CFG_W-1:0]  cfg_data = 0;
  logic              out_valid, out_found, out_hot, out_last;
  logic [3:0]        out_part_index;
  logic [RATE_W-1:0] out_read_rate, out_write_rate;
  logic [CPU_W-1:0]  out_cpu_average;

  load_scoreboard    sb = new();
  longint unsigned   cycles = 0;
  int                sent = 0;
  int                gap_pct = 12;

  partition_load_hotspot_monitor_core uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    part_report_t got;
    if (rst_n && out_valid) begin
      got.found = out_found; got.idx = out_part_index;
      got.rd_rate = out_read_rate; got.wr_rate = out_write_rate;
      got.cpu_avg = out_cpu_average; got.hot = out_hot; got.last = out_last;
      sb.check(got);
    end
  end

  task automatic send(bit [2:0] op, bit [3:0] p, bit wr, bit [15:0] cnt,
                      bit [23:0] smp);
    @(negedge clk);
    start = 1; in_op = op; in_partition = p; in_is_write = wr;
    in_access_count = cnt; in_cpu_sample = smp;
    do @(posedge clk); while (busy);
    sb.note(op, p, wr, cnt, smp);
    sent++;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  // Hold off until every answer is back and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    start = 0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, longint unsigned val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = CFG_W'(val);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_item();
    int          sel;
    bit [3:0]    p;
    bit [15:0]   cnt;
    bit [23:0]   smp;
    bit          wr;
    sel = $urandom_range(99);
    p = 4'($urandom_range(15));
    cnt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    smp = ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(90000));
    wr = 1'($urandom);
    if (sel < 48)      send(plhm_pkg::OP_ACCESS, p, wr, cnt, smp);
    else if (sel < 74) send(plhm_pkg::OP_CPU, p, wr, cnt, smp);
    else if (sel < 88) send(plhm_pkg::OP_QUERY, p, wr, cnt, smp);
    else if (sel < 93) send(plhm_pkg::OP_DETECT, p, wr, cnt, smp);
    else if (sel < 96) send(plhm_pkg::OP_CLEAR, p, wr, cnt, smp);
    else               send(3'($urandom_range(7, 5)), p, wr, cnt, smp);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty table, extremes, tie ordering, ignored codes
    send(plhm_pkg::OP_QUERY, 0, 0, 0, 0);
    send(plhm_pkg::OP_DETECT, 0, 0, 0, 0);
    send(plhm_pkg::OP_ACCESS, 0, 1, 16'hFFFF, 0);
    send(plhm_pkg::OP_ACCESS, 15, 0, 0, 24'hFFFFFF);
    send(plhm_pkg::OP_CPU, 3, 0, 0, 24'hFFFFFF);
    send(plhm_pkg::OP_CPU, 4, 1, 16'hFFFF, 0);
    send(plhm_pkg::OP_ACCESS, 5, 0, 16'hFFFF, 0);
    send(plhm_pkg::OP_ACCESS, 7, 1, 16'hFFFF, 0);
    send(plhm_pkg::OP_QUERY, 0, 0, 0, 0);
    send(plhm_pkg::OP_QUERY, 15, 1, 16'hFFFF, 24'hFFFFFF);
    send(plhm_pkg::OP_QUERY, 3, 0, 0, 0);
    send(plhm_pkg::OP_DETECT, 0, 0, 0, 0);
    send(3'd5, 1, 1, 16'hFFFF, 24'hFFFFFF);
    send(3'd6, 2, 0, 5, 5);
    send(3'd7, 9, 1, 7, 7);
    send(plhm_pkg::OP_CLEAR, 0, 0, 0, 0);
    send(plhm_pkg::OP_DETECT, 0, 0, 0, 0);
    send(plhm_pkg::OP_QUERY, 7, 0, 0, 0);
    drain();

    write_reg(plhm_pkg::REG_INTERVAL, 0);
    write_reg(plhm_pkg::REG_RATE_THR, (64'd1 << THR_W) - 1);
    write_reg(plhm_pkg::REG_CPU_THR, 0);
    write_reg(plhm_pkg::REG_WINDOW, 0);
    send(plhm_pkg::OP_ACCESS, 2, 0, 1, 0);
    send(plhm_pkg::OP_QUERY, 2, 0, 0, 0);
    send(plhm_pkg::OP_DETECT, 0, 0, 0, 0);
    for (int k = 0; k < 110; k++) begin
      if (sent >= 150) gap_pct = 71;
      random_item();
    end
    drain();

    write_reg(plhm_pkg::REG_INTERVAL, 16'hFFFF);
    write_reg(plhm_pkg::REG_RATE_THR, 0);
    write_reg(plhm_pkg::REG_CPU_THR, 24'hFFFFFF);
    write_reg(plhm_pkg::REG_WINDOW, 8'hFF);
    for (int k = 0; k < 110; k++) begin
      if (sent >= 150) gap_pct = 71;
      random_item();
    end
    drain();

    write_reg(plhm_pkg::REG_INTERVAL, 1);
    write_reg(plhm_pkg::REG_RATE_THR, 30000);
    write_reg(plhm_pkg::REG_CPU_THR, 40000);
    write_reg(plhm_pkg::REG_WINDOW, 1);
    for (int k = 0; k < 110; k++) begin
      if (sent >= 300) gap_pct = 0;
      random_item();
    end
    drain();

    write_reg(plhm_pkg::REG_INTERVAL, 64'($urandom_range(2000, 1)));
    write_reg(plhm_pkg::REG_RATE_THR, 64'($urandom_range(20000)));
    write_reg(plhm_pkg::REG_CPU_THR, 64'($urandom_range(80000)));
    write_reg(plhm_pkg::REG_WINDOW, 64'($urandom_range(12, 2)));
    gap_pct = 0;
    for (int k = 0; k < 110; k++) random_item();
    drain();

    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
